FILE: rtl/core/adc_mv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ADC millivolt converter package
// Shared widths, pipeline layout and status codes.
// ----------------------------------------------------------------------------
package adc_mv_pkg;

  localparam int AccW   = 49;  // widest dividend: 48-bit product plus rounding term
  localparam int QuoW   = 32;
  localparam int Div1W  = 16;  // first quotient never exceeds the 16-bit reference
  localparam int Div2W  = 32;

  // Pipeline layout.
  localparam int StMul1  = 1;
  localparam int StDiv1  = 2;
  localparam int StMul2  = StDiv1 + Div1W;
  localparam int StOvf   = StMul2 + 1;
  localparam int StDiv2  = StOvf + 1;
  localparam int StLast  = StDiv2 + Div2W - 1;

  localparam logic [5:0] MaxRes = 6'd32;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_SET  = 2'd1,
    STATUS_ABOVE_FS = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [7:0] {
    REG_REF   = 8'd0,
    REG_RES   = 8'd1,
    REG_NUM   = 8'd2,
    REG_DEN   = 8'd3
  } reg_idx_t;

  typedef struct packed {
    logic [AccW-1:0] acc;
    logic [QuoW-1:0] quo;
    status_t         status;
  } stage_t;

endpackage
`default_nettype wire

FILE: rtl/core/adc_code_to_scaled_millivolts.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ADC code to scaled millivolts
// Converts a raw ADC code to millivolts with two rounded ratio scalings.
// ----------------------------------------------------------------------------
// The block takes one request per cycle unless a finished result is stalled,
// and returns one result per request, in order. The pipeline has 52 register
// stages; the depth comes from two restoring dividers, one stage per quotient
// bit: 16 stages for the division by full scale and 32 stages for the
// division by the scale denominator, plus capture, two multiply stages and
// an overflow check. The whole pipeline advances together and freezes while
// a finished result is stalled, so nothing is lost or repeated. Errors are
// decided at entry (bad settings, code above full scale) or before the second
// division (result above 32 bits) and travel with the data; mv_out reads
// zero whenever status is not ok. Configuration is written through a simple
// write port and must only change while the pipeline is empty.
module adc_code_to_scaled_millivolts (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] raw_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      mv_out,
  output logic [1:0]       status
);

  logic [15:0] reference_millivolts;
  logic [5:0]  adc_bits;
  logic [31:0] scale_numerator;
  logic [31:0] scale_denominator;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_millivolts <= 16'd3300;
      adc_bits             <= 6'd12;
      scale_numerator      <= 32'd1;
      scale_denominator    <= 32'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        adc_mv_pkg::REG_REF: reference_millivolts <= cfg_data[15:0];
        adc_mv_pkg::REG_RES: adc_bits             <= cfg_data[5:0];
        adc_mv_pkg::REG_NUM: scale_numerator      <= cfg_data;
        adc_mv_pkg::REG_DEN: scale_denominator    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Full scale is all ones in the low adc_bits bits. It is only
  // meaningful when the resolution is in range; otherwise status overrides.
  logic [5:0]  fs_shift;
  logic [31:0] full_scale;
  logic        bad_setting;

  assign fs_shift    = adc_mv_pkg::MaxRes - adc_bits;
  assign full_scale  = 32'hFFFF_FFFF >> fs_shift;
  assign bad_setting = (scale_numerator == 32'd0) || (scale_denominator == 32'd0) ||
                       (reference_millivolts == 16'd0) || (adc_bits == 6'd0) ||
                       (adc_bits > adc_mv_pkg::MaxRes);

  adc_mv_pkg::stage_t pipe [0:adc_mv_pkg::StLast];
  adc_mv_pkg::stage_t nx   [0:adc_mv_pkg::StLast];
  logic vld [0:adc_mv_pkg::StLast];
  logic advance;

  // The pipeline moves as one; it holds only while the finished result waits.
  assign advance   = !(vld[adc_mv_pkg::StLast] && out_stall);
  assign in_stall  = !advance;
  assign out_valid = vld[adc_mv_pkg::StLast];

  // Entry: classify the request before any arithmetic.
  always_comb begin
    nx[0].acc = {{(adc_mv_pkg::AccW - 32){1'b0}}, raw_code};
    nx[0].quo = '0;
    if (bad_setting) begin
      nx[0].status = adc_mv_pkg::STATUS_BAD_SET;
    end else if (raw_code > full_scale) begin
      nx[0].status = adc_mv_pkg::STATUS_ABOVE_FS;
    end else begin
      nx[0].status = adc_mv_pkg::STATUS_OK;
    end
  end

  genvar s;
  generate
    for (s = 1; s <= adc_mv_pkg::StLast; s++) begin : g_stage
      if (s == adc_mv_pkg::StMul1) begin : g_mul1
        // code * reference plus half of full scale for rounding.
        logic [47:0] prod;
        assign prod = pipe[s-1].acc[31:0] * reference_millivolts;
        always_comb begin
          nx[s]     = pipe[s-1];
          nx[s].acc = {1'b0, prod} + {17'd0, 1'b0, full_scale[31:1]};
          nx[s].quo = '0;
        end
      end else if (s < adc_mv_pkg::StMul2) begin : g_div1
        // One quotient bit per stage, most significant first.
        localparam int Bit = adc_mv_pkg::StMul2 - 1 - s;
        logic [63:0] sh;
        assign sh = {32'd0, full_scale} << Bit;
        always_comb begin
          nx[s] = pipe[s-1];
          if ({15'd0, pipe[s-1].acc} >= sh) begin
            nx[s].acc      = pipe[s-1].acc - sh[adc_mv_pkg::AccW-1:0];
            nx[s].quo[Bit] = 1'b1;
          end
        end
      end else if (s == adc_mv_pkg::StMul2) begin : g_mul2
        // Unscaled value times numerator plus half the denominator.
        logic [47:0] prod;
        assign prod = pipe[s-1].quo[adc_mv_pkg::Div1W-1:0] * scale_numerator;
        always_comb begin
          nx[s]     = pipe[s-1];
          nx[s].acc = {1'b0, prod} + {17'd0, 1'b0, scale_denominator[31:1]};
          nx[s].quo = '0;
        end
      end else if (s == adc_mv_pkg::StOvf) begin : g_ovf
        // The quotient exceeds 32 bits exactly when the dividend reaches
        // the denominator shifted up by 32.
        always_comb begin
          nx[s] = pipe[s-1];
          if ((pipe[s-1].status == adc_mv_pkg::STATUS_OK) &&
              ({15'd0, pipe[s-1].acc} >= {scale_denominator, 32'd0})) begin
            nx[s].status = adc_mv_pkg::STATUS_OVERFLOW;
          end
        end
      end else begin : g_div2
        localparam int Bit = adc_mv_pkg::StLast - s;
        logic [63:0] sh;
        assign sh = {32'd0, scale_denominator} << Bit;
        always_comb begin
          nx[s] = pipe[s-1];
          if ({15'd0, pipe[s-1].acc} >= sh) begin
            nx[s].acc      = pipe[s-1].acc - sh[adc_mv_pkg::AccW-1:0];
            nx[s].quo[Bit] = 1'b1;
          end
        end
      end
    end

    for (s = 0; s <= adc_mv_pkg::StLast; s++) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[s] <= 1'b0;
        end else if (advance) begin
          vld[s] <= (s == 0) ? in_valid : vld[(s == 0) ? 0 : s - 1];
        end
      end

      always_ff @(posedge clk) begin
        if (advance) begin
          pipe[s] <= nx[s];
        end
      end
    end
  endgenerate

  assign status = pipe[adc_mv_pkg::StLast].status;
  assign mv_out = (pipe[adc_mv_pkg::StLast].status == adc_mv_pkg::STATUS_OK) ?
                  pipe[adc_mv_pkg::StLast].quo : 32'd0;

endmodule
`default_nettype wire

FILE: sim/tb_adc_code_to_scaled_millivolts.sv
// ----------------------------------------------------------------------------
// Testbench for the ADC code to scaled millivolts converter
// Drives raw codes through the valid/stall request channel under several
// register settings. Each accepted request is predicted in the bench. Each
// result is checked, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_adc_code_to_scaled_millivolts;

  // This drain pause covers the depth of the pipeline.
  localparam int DrainCycles = 80;
  // A request waits at most one random idle gap plus the pipeline depth.
  // A result waits at most one random stall. This limit is far above both.
  localparam int WatchLimit  = 3000;
  // Indexes past the last register. The block must ignore a write to them.
  localparam logic [7:0] RegUnused = 8'd4;
  localparam logic [7:0] RegTopIdx = 8'hFF;

  typedef struct packed {
    logic [31:0]          mv;
    adc_mv_pkg::status_t  st;
  } mv_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] raw_code = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] mv_out;
  logic [1:0]  status;

  // These are the bench's own copies of the four registers.
  logic [15:0] vref_mv;
  logic [5:0]  res_bits;
  logic [31:0] ratio_num;
  logic [31:0] ratio_den;

  mv_result_t  mv_expected_q[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          out_hold = 0;
  bit          no_idle = 0;

  adc_code_to_scaled_millivolts u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .raw_code(raw_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .mv_out(mv_out), .status(status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // This computes the expected millivolts and status for one code. It rounds
  // both ratios half up. It uses the settings as they are when the request
  // is accepted.
  function automatic mv_result_t convert_code(input logic [31:0] code);
    mv_result_t  r;
    logic [63:0] fs;
    logic [63:0] unscaled;
    logic [63:0] scaled;
    r.mv = '0;
    r.st = adc_mv_pkg::STATUS_OK;
    if (ratio_num == 0 || ratio_den == 0) begin
      r.st = adc_mv_pkg::STATUS_BAD_SET;
    end else if (vref_mv == 0 || res_bits == 0 || res_bits > 6'd32) begin
      r.st = adc_mv_pkg::STATUS_BAD_SET;
    end else begin
      fs = (64'd1 << res_bits) - 64'd1;
      if ({32'd0, code} > fs) begin
        r.st = adc_mv_pkg::STATUS_ABOVE_FS;
      end else begin
        unscaled = ({32'd0, code} * {48'd0, vref_mv} + fs / 2) / fs;
        scaled = (unscaled * {32'd0, ratio_num} + {32'd0, ratio_den} / 2)
                 / {32'd0, ratio_den};
        if (scaled > 64'hFFFF_FFFF) r.st = adc_mv_pkg::STATUS_OVERFLOW;
        else r.mv = scaled[31:0];
      end
    end
    return r;
  endfunction

  // The result side draws a random stall, possibly none, after each result.
  // Every accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    mv_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (mv_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: mv=%0d status=%0d", mv_out, status);
      end else begin
        want = mv_expected_q.pop_front();
        if (mv_out !== want.mv || status !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected mv=%0d status=%0d, got mv=%0d status=%0d",
                     want.mv, want.st, mv_out, status);
        end
      end
      out_hold = no_idle ? 0 : $urandom_range(0, 9);
    end else if (out_hold > 0) begin
      out_hold--;
    end
    out_stall <= (out_hold > 0);
  end

  // The watchdog ends the run when neither channel accepts anything for
  // too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("tb_adc_code_to_scaled_millivolts: FAIL");
      $finish;
    end
  end

  // This sends one code after a random gap. A valid that stays high for
  // back-to-back requests is never dropped in between.
  task automatic send_code(input logic [31:0] code);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_code <= code;
    do @(posedge clk); while (in_stall);
    mv_expected_q.push_back(convert_code(code));
  endtask

  // This waits until no result is owed and the pipeline has drained.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (mv_expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Registers change only while the block is empty. The bench keeps only
  // the low bits of the data, as the hardware does.
  task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      adc_mv_pkg::REG_REF: vref_mv   = data[15:0];
      adc_mv_pkg::REG_RES: res_bits  = data[5:0];
      adc_mv_pkg::REG_NUM: ratio_num = data;
      adc_mv_pkg::REG_DEN: ratio_den = data;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [31:0] vref, input logic [31:0] res,
                         input logic [31:0] num, input logic [31:0] den);
    write_reg(adc_mv_pkg::REG_REF, vref);
    write_reg(adc_mv_pkg::REG_RES, res);
    write_reg(adc_mv_pkg::REG_NUM, num);
    write_reg(adc_mv_pkg::REG_DEN, den);
  endtask

  // The reset settings are 3300 mV and 12 bits. The codes cover zero, full
  // scale, one above it and the largest code.
  task automatic test_reset_settings;
    send_code(32'd0);
    send_code(32'd4095);
    send_code(32'd2048);
    send_code(32'd4096);
    send_code(32'hFFFF_FFFF);
  endtask

  // Each invalid setting must give the invalid setting status and zero
  // volts. A zero scale term takes priority over a code above full scale.
  task automatic test_bad_settings;
    set_all(1000, 10, 0, 1);
    send_code(32'd5);
    send_code(32'hFFFF_FFFF);
    set_all(1000, 10, 1, 0);
    send_code(32'd5);
    set_all(0, 10, 1, 1);
    send_code(32'd5);
    write_reg(adc_mv_pkg::REG_REF, 32'hABCD_0000);  // only the low half lands, still zero
    send_code(32'd7);
    set_all(1000, 0, 1, 1);
    send_code(32'd0);
    write_reg(adc_mv_pkg::REG_RES, 33);
    send_code(32'd1);
    write_reg(adc_mv_pkg::REG_RES, 32'hFFFF_FFFF);  // oversized data keeps 63
    send_code(32'd1);
  endtask

  // This covers the extremes of resolution and reference, and a result
  // that exceeds 32 bits.
  task automatic test_extremes;
    set_all(65535, 32, 1, 1);
    send_code(32'd0);
    send_code(32'hFFFF_FFFF);
    send_code(32'h7FFF_FFFF);
    write_reg(adc_mv_pkg::REG_RES, 32'hFFFF_FFC1);  // oversized data keeps 1
    send_code(32'd0);
    send_code(32'd1);
    send_code(32'd2);
    write_reg(adc_mv_pkg::REG_NUM, 32'hFFFF_FFFF);
    send_code(32'd1);
    write_reg(adc_mv_pkg::REG_DEN, 32'hFFFF_FFFF);
    send_code(32'd1);
  endtask

  // A write to an index past the last register must change nothing.
  task automatic test_unknown_index;
    set_all(2500, 8, 3, 2);
    write_reg(RegUnused, 32'd0);
    write_reg(RegTopIdx, 32'd0);
    send_code(32'd255);
    send_code(32'd100);
  endtask

  // Random phases use mostly valid settings and codes within full scale.
  // A few settings are invalid and a few codes are out of range. Some
  // phases run with no idling on either side.
  task automatic test_random;
    logic [31:0] fs;
    logic [31:0] code;
    for (int ph = 0; ph < 10; ph++) begin
      if ($urandom_range(0, 9) == 0) write_reg(adc_mv_pkg::REG_REF, $urandom);
      else write_reg(adc_mv_pkg::REG_REF, $urandom_range(1, 65535));
      if ($urandom_range(0, 9) == 0) write_reg(adc_mv_pkg::REG_RES, $urandom);
      else write_reg(adc_mv_pkg::REG_RES, $urandom_range(1, 32));
      case ($urandom_range(0, 3))
        0: write_reg(adc_mv_pkg::REG_NUM, $urandom);
        1: write_reg(adc_mv_pkg::REG_NUM, $urandom_range(0, 1000));
        default: write_reg(adc_mv_pkg::REG_NUM, $urandom_range(1, 20));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(adc_mv_pkg::REG_DEN, $urandom);
        1: write_reg(adc_mv_pkg::REG_DEN, $urandom_range(0, 1000));
        default: write_reg(adc_mv_pkg::REG_DEN, $urandom_range(1, 20));
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      fs = (res_bits == 0 || res_bits >= 32) ? 32'hFFFF_FFFF
                                             : (32'd1 << res_bits) - 32'd1;
      for (int k = 0; k < 100; k++) begin
        code = $urandom;
        if ($urandom_range(0, 9) != 0) code = code & fs;
        send_code(code);
      end
      no_idle = 0;
    end
  endtask

  initial begin
    vref_mv   = 16'd3300;
    res_bits  = 6'd12;
    ratio_num = 32'd1;
    ratio_den = 32'd1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_settings();
    test_bad_settings();
    test_extremes();
    test_unknown_index();
    test_random();
    drain();
    if (mismatches == 0) begin
      $display("tb_adc_code_to_scaled_millivolts: PASS");
    end else begin
      $display("tb_adc_code_to_scaled_millivolts: FAIL");
    end
    $finish;
  end

endmodule
